FILE: sv/mpq_pkg.sv
// mpq_pkg: shared types, constants and helpers of the multiclass priority event queue
// depends on: nothing
package mpq_pkg;

	// sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_WIDTH = 16;
	localparam int TAG_FIELD_W = 16;
	localparam int NUM_CLASSES = 3;
	localparam int NUM_LEVELS = 3;
	localparam int NUM_QUEUES = NUM_CLASSES * NUM_LEVELS;
	localparam int NUM_CELLS = NUM_QUEUES * QUEUE_DEPTH;
	localparam int QIDX_W = $clog2(NUM_QUEUES);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_W = (TAG_WIDTH < TAG_FIELD_W) ? TAG_WIDTH : TAG_FIELD_W;

	// request codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// field codes for results that carry no event
	localparam logic [1:0] CLASS_NONE = 2'd0;
	localparam logic [1:0] PRIO_NONE = 2'd2;

	// one slot of the sorted chain
	typedef struct packed {
		logic               valid;
		logic [QIDX_W-1:0]  qidx;
		logic [STORE_W-1:0] tag;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic               insert;
		logic               remove;
		logic [QIDX_W-1:0]  qidx;
		logic [STORE_W-1:0] tag;
	} cell_ctrl_t;

	// occupancy flags toward the control logic
	typedef struct packed {
		logic full;
		logic any;
	} occ_stat_t;

	// sub-queue index from normalized class and priority
	function automatic logic [QIDX_W-1:0] queue_index(input logic [1:0] cls,
			input logic [1:0] prio);
		logic [1:0] c;
		logic [1:0] p;
		c = (cls == 2'd3) ? 2'd0 : cls;
		p = (prio == 2'd3) ? 2'd2 : prio;
		return QIDX_W'({c, 1'b0}) + QIDX_W'(c) + QIDX_W'(p);
	endfunction

	// class of a sub-queue index
	function automatic logic [1:0] qidx_class(input logic [QIDX_W-1:0] q);
		logic [1:0] r;
		case (q)
			QIDX_W'(0), QIDX_W'(1), QIDX_W'(2): r = 2'd0;
			QIDX_W'(3), QIDX_W'(4), QIDX_W'(5): r = 2'd1;
			default:                             r = 2'd2;
		endcase
		return r;
	endfunction

	// priority of a sub-queue index
	function automatic logic [1:0] qidx_prio(input logic [QIDX_W-1:0] q);
		logic [1:0] r;
		case (q)
			QIDX_W'(0), QIDX_W'(3), QIDX_W'(6): r = 2'd0;
			QIDX_W'(1), QIDX_W'(4), QIDX_W'(7): r = 2'd1;
			default:                             r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/mpq_cell.sv
// mpq_cell: one slot of the sorted event chain, shifts with its neighbors
// depends on: mpq_pkg
module mpq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mpq_pkg::cell_ctrl_t ctrl,
	input  mpq_pkg::entry_t    left,
	input  mpq_pkg::entry_t    right,
	output mpq_pkg::entry_t    entry
);

	logic                         valid_q;
	logic [mpq_pkg::QIDX_W-1:0]   qidx_q;
	logic [mpq_pkg::STORE_W-1:0]  tag_q;
	mpq_pkg::entry_t entry_q;
	mpq_pkg::entry_t entry_d;
	logic            left_le;
	logic            own_gt;

	assign entry_q = {valid_q, qidx_q, tag_q};

	// ordering against the new event: equal keys stay ahead of it
	assign left_le = left.valid && (left.qidx <= ctrl.qidx);
	assign own_gt = !entry_q.valid || (entry_q.qidx > ctrl.qidx);

	// next slot content
	always_comb begin
		entry_d = entry_q;
		if (ctrl.remove) begin
			entry_d = right;
		end else if (ctrl.insert) begin
			if (left_le && own_gt) begin
				entry_d.valid = 1'b1;
				entry_d.qidx = ctrl.qidx;
				entry_d.tag = ctrl.tag;
			end else if (!left_le) begin
				entry_d = left;
			end
		end
	end

	// slot register, only the valid bit is reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		qidx_q <= entry_d.qidx;
		tag_q <= entry_d.tag;
	end

	assign entry = entry_q;

endmodule

FILE: sv/mpq_occupancy.sv
// mpq_occupancy: fill counters of the nine sub-queues
// depends on: mpq_pkg
module mpq_occupancy (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mpq_pkg::cell_ctrl_t         ctrl,
	input  logic [mpq_pkg::QIDX_W-1:0]  lookup_qidx,
	input  mpq_pkg::entry_t             head,
	output mpq_pkg::occ_stat_t          stat
);

	logic [mpq_pkg::CNT_W-1:0] count_q [mpq_pkg::NUM_QUEUES];
	logic [mpq_pkg::NUM_QUEUES-1:0] nonzero;

	// count up on a stored insert, down when the head leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mpq_pkg::NUM_QUEUES; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			if (ctrl.insert) begin
				count_q[ctrl.qidx] <= count_q[ctrl.qidx] + 1'b1;
			end else if (ctrl.remove && head.valid) begin
				count_q[head.qidx] <= count_q[head.qidx] - 1'b1;
			end
		end
	end

	// status toward the control logic
	always_comb begin
		for (int i = 0; i < mpq_pkg::NUM_QUEUES; i++) begin
			nonzero[i] = (count_q[i] != '0);
		end
	end

	assign stat.full = (count_q[lookup_qidx] == mpq_pkg::CNT_W'(mpq_pkg::QUEUE_DEPTH));
	assign stat.any = |nonzero;

endmodule

FILE: sv/multiclass_priority_event_queue.sv
// multiclass_priority_event_queue: top level, sorted cell chain plus fill counters
// depends on: mpq_pkg, mpq_cell, mpq_occupancy
//
//  channel   handshake          payload
//  request   start / busy       opcode, event_tag, event_class, event_priority
//  result    done (strobe)      status, removed_tag, removed_class, removed_priority
//
// one request per clock cycle; its result strobes on done in the following cycle
// the chain keeps events sorted by sub-queue, arrival order inside a sub-queue;
// an insert shifts the tail of the chain right, a remove shifts the whole chain left
// busy is high only while reset is applied; reset empties the chain and the counters
// the receiver cannot stall: each result is shown for exactly one cycle
module multiclass_priority_event_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [15:0] event_tag,
	input  logic [1:0]  event_class,
	input  logic [1:0]  event_priority,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] removed_tag,
	output logic [1:0]  removed_class,
	output logic [1:0]  removed_priority
);

	logic                        accept;
	logic [mpq_pkg::QIDX_W-1:0]  req_qidx;
	mpq_pkg::cell_ctrl_t         ctrl;
	mpq_pkg::occ_stat_t          occ;
	mpq_pkg::entry_t             chain [mpq_pkg::NUM_CELLS];
	mpq_pkg::entry_t             head;
	mpq_pkg::entry_t             chain_front;
	mpq_pkg::entry_t             chain_back;

	logic                        done_q;
	mpq_pkg::status_t            status_q;
	logic [15:0]                 tag_q;
	logic [1:0]                  class_q;
	logic [1:0]                  prio_q;

	// request decode
	assign busy = ~arst_n;
	assign accept = start && !busy;
	assign req_qidx = mpq_pkg::queue_index(event_class, event_priority);

	always_comb begin
		ctrl.insert = accept && (opcode == mpq_pkg::OP_INSERT) && !occ.full;
		ctrl.remove = accept && (opcode == mpq_pkg::OP_REMOVE);
		ctrl.qidx = req_qidx;
		ctrl.tag = event_tag[mpq_pkg::STORE_W-1:0];
	end

	// chain ends: front acts as smallest key, back as empty slot
	always_comb begin
		chain_front = '0;
		chain_front.valid = 1'b1;
		chain_back = '0;
	end

	assign head = chain[0];

	// row of cells
	for (genvar i = 0; i < mpq_pkg::NUM_CELLS; i++) begin : g_cell
		mpq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   ((i == 0) ? chain_front : chain[(i == 0) ? 0 : i - 1]),
			.right  ((i == mpq_pkg::NUM_CELLS - 1) ? chain_back :
				chain[(i == mpq_pkg::NUM_CELLS - 1) ? i : i + 1]),
			.entry  (chain[i])
		);
	end

	// fill counters
	mpq_occupancy u_occupancy (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.lookup_qidx (req_qidx),
		.head        (head),
		.stat        (occ)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (opcode == mpq_pkg::OP_INSERT) begin
				status_q <= occ.full ? mpq_pkg::ST_FULL : mpq_pkg::ST_INSERTED;
				tag_q <= '0;
				class_q <= mpq_pkg::CLASS_NONE;
				prio_q <= mpq_pkg::PRIO_NONE;
			end else if (head.valid) begin
				status_q <= mpq_pkg::ST_REMOVED;
				tag_q <= 16'(head.tag);
				class_q <= mpq_pkg::qidx_class(head.qidx);
				prio_q <= mpq_pkg::qidx_prio(head.qidx);
			end else begin
				status_q <= mpq_pkg::ST_EMPTY;
				tag_q <= '0;
				class_q <= mpq_pkg::CLASS_NONE;
				prio_q <= mpq_pkg::PRIO_NONE;
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign removed_tag = tag_q;
	assign removed_class = class_q;
	assign removed_priority = prio_q;

	// a result follows exactly one accepted request
	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result without request");

	// head slot holds an event exactly when some counter is nonzero
	a_head_matches_counts: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid == occ.any)
		else $error("chain head and fill counters disagree");

	// a removed event was at the head in the cycle before its result
	a_removed_from_head: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == mpq_pkg::ST_REMOVED) |-> $past(head.valid))
		else $error("removal reported with empty chain");

	// chain stays ordered at the front
	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		chain[1].valid |-> (chain[0].valid && chain[0].qidx <= chain[1].qidx))
		else $error("chain order broken at head");

endmodule
